>>> hw/rtl/bte_pkg.sv
package bte_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int ADDR_WIDTH  = 32;
  localparam int INST_BYTES  = 2;
  localparam int MAX_RESULTS = 8;

  localparam int INST_W = 16;
  localparam int SLOT_W = 3;
  localparam int CMD_W  = 3;
  localparam int LEN_W  = 8;
  localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register select is paddr bit 2 (word index)
  localparam logic REG_BPT_INST = 1'b0;

  typedef logic [ADDR_WIDTH-1:0] addr_t;
  typedef logic [INST_W-1:0]     inst_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [CMD_W-1:0]      cmd_t;
  typedef logic [CFG_DW-1:0]     cfg_data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET        = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_REMOVE_ALL = 3'd2,
    CMD_MASK       = 3'd3,
    CMD_UNMASK     = 3'd4,
    CMD_RANGE      = 3'd5,
    CMD_FIND       = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_SET_WR,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    addr_t addr;
    inst_t saved;
    logic  active;
  } entry_t;

  typedef struct packed {
    logic  status;
    logic  found;
    slot_t result_slot;
    logic  mem_write;
    addr_t write_addr;
    inst_t write_data;
  } res_t;

  typedef struct packed {
    logic   shift;
    entry_t tail;
  } chain_ctl_t;

endpackage

>>> hw/rtl/bte_in_if.sv
interface bte_in_if;
  logic                 valid;
  logic                 ready;
  bte_pkg::cmd_t        cmd;
  bte_pkg::slot_t       slot;
  logic                 any_slot;
  bte_pkg::addr_t       addr;
  bte_pkg::len_t        length;
  bte_pkg::inst_t       displaced_inst;

  modport source (output valid, cmd, slot, any_slot, addr, length, displaced_inst,
                  input ready);
  modport sink   (input valid, cmd, slot, any_slot, addr, length, displaced_inst,
                  output ready);
endinterface

>>> hw/rtl/bte_out_if.sv
interface bte_out_if;
  logic            valid;
  logic            ready;
  logic            status;
  logic            found;
  bte_pkg::slot_t  result_slot;
  logic            mem_write;
  bte_pkg::addr_t  write_addr;
  bte_pkg::inst_t  write_data;
  logic            last;

  modport source (output valid, status, found, result_slot, mem_write, write_addr,
                  write_data, last, input ready);
  modport sink   (input valid, status, found, result_slot, mem_write, write_addr,
                  write_data, last, output ready);
endinterface

>>> hw/rtl/bte_cell.sv
module bte_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  bte_pkg::entry_t  d,
  output bte_pkg::entry_t  q
);

  logic           active_r;
  bte_pkg::addr_t addr_r;
  bte_pkg::inst_t saved_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (shift) begin
      active_r <= d.active;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      addr_r  <= d.addr;
      saved_r <= d.saved;
    end
  end

  assign q = '{addr: addr_r, saved: saved_r, active: active_r};

endmodule

>>> hw/rtl/bte_ctrl.sv
module bte_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  bte_in_if.sink               in_ch,
  bte_out_if.source            out_ch,
  input  bte_pkg::inst_t       bpt_inst,
  input  bte_pkg::entry_t      head,
  output bte_pkg::chain_ctl_t  chain_ctl
);

  bte_pkg::state_e state_r, state_nxt;

  // command payload
  bte_pkg::cmd_t  cmd_r, cmd_nxt;
  bte_pkg::slot_t slot_r, slot_nxt;
  logic           any_r, any_nxt;
  bte_pkg::addr_t addr_r, addr_nxt;
  bte_pkg::len_t  len_r, len_nxt;
  bte_pkg::inst_t dinst_r, dinst_nxt;

  // pass control and accumulators
  bte_pkg::idx_t  k_r, k_nxt;
  bte_pkg::cnt_t  cnt_r, cnt_nxt;
  logic           set_ph_r, set_ph_nxt;
  logic           dup_r, dup_nxt;
  logic           have_r, have_nxt;
  bte_pkg::idx_t  free_r, free_nxt;
  bte_pkg::idx_t  tgt_r, tgt_nxt;
  logic           hit_r, hit_nxt;
  logic           found_r, found_nxt;
  bte_pkg::idx_t  fidx_r, fidx_nxt;

  // pending result and output register
  logic           pend_valid_r, pend_valid_nxt;
  bte_pkg::res_t  pend_r, pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  bte_pkg::res_t  out_r, out_nxt;
  logic           out_last_r, out_last_nxt;

  logic           out_free;
  logic           emit_ok;
  logic           want_emit;
  bte_pkg::res_t  emit_item;
  bte_pkg::res_t  dflt_item;
  logic           adv;
  logic           head_match;
  logic           range_hit;
  logic           slot_oob;
  logic           set_err;
  bte_pkg::addr_t d_up;
  bte_pkg::addr_t d_dn;
  bte_pkg::entry_t tail;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign emit_ok    = !pend_valid_r || out_free;
  assign head_match = head.active && (head.addr == addr_r);
  assign slot_oob   = (32'(slot_r) >= 32'(bte_pkg::NUM_ENTRIES));

  // overlap: access starts inside the breakpoint, or breakpoint inside the access
  assign d_up      = addr_r - head.addr;
  assign d_dn      = head.addr - addr_r;
  assign range_hit = head.active &&
                     ((addr_r >= head.addr) ? (d_up < bte_pkg::addr_t'(bte_pkg::INST_BYTES))
                                            : (d_dn < bte_pkg::addr_t'(len_r)));

  always_comb begin
    dflt_item = '0;
    unique case (bte_pkg::cmd_e'(cmd_r))
      bte_pkg::CMD_RANGE: dflt_item.status = hit_r;
      bte_pkg::CMD_FIND: begin
        dflt_item.found       = found_r;
        dflt_item.result_slot = bte_pkg::slot_t'(fidx_r);
      end
      bte_pkg::CMD_REMOVE_ALL, bte_pkg::CMD_MASK, bte_pkg::CMD_UNMASK: ;
      default: dflt_item.status = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bte_pkg::ST_IDLE;
      k_r          <= '0;
      cnt_r        <= '0;
      set_ph_r     <= 1'b0;
      dup_r        <= 1'b0;
      have_r       <= 1'b0;
      hit_r        <= 1'b0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      cnt_r        <= cnt_nxt;
      set_ph_r     <= set_ph_nxt;
      dup_r        <= dup_nxt;
      have_r       <= have_nxt;
      hit_r        <= hit_nxt;
      found_r      <= found_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    slot_r     <= slot_nxt;
    any_r      <= any_nxt;
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    dinst_r    <= dinst_nxt;
    free_r     <= free_nxt;
    tgt_r      <= tgt_nxt;
    fidx_r     <= fidx_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    any_nxt        = any_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    dinst_nxt      = dinst_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    set_ph_nxt     = set_ph_r;
    dup_nxt        = dup_r;
    have_nxt       = have_r;
    free_nxt       = free_r;
    tgt_nxt        = tgt_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    fidx_nxt       = fidx_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    want_emit      = 1'b0;
    emit_item      = '0;
    tail           = head;
    adv            = 1'b0;
    set_err        = 1'b0;
    in_ch.ready    = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bte_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt    = in_ch.cmd;
          slot_nxt   = in_ch.slot;
          any_nxt    = in_ch.any_slot;
          addr_nxt   = in_ch.addr;
          len_nxt    = in_ch.length;
          dinst_nxt  = in_ch.displaced_inst;
          k_nxt      = '0;
          cnt_nxt    = '0;
          set_ph_nxt = 1'b0;
          dup_nxt    = 1'b0;
          have_nxt   = 1'b0;
          free_nxt   = '0;
          hit_nxt    = 1'b0;
          found_nxt  = 1'b0;
          fidx_nxt   = '0;
          state_nxt  = (in_ch.cmd > bte_pkg::cmd_t'(bte_pkg::CMD_FIND)) ?
                       bte_pkg::ST_FLUSH : bte_pkg::ST_PASS;
        end
      end

      bte_pkg::ST_PASS: begin
        emit_item.result_slot = bte_pkg::slot_t'(k_r);
        emit_item.mem_write   = 1'b1;
        emit_item.write_addr  = head.addr;
        emit_item.write_data  = head.saved;
        unique case (bte_pkg::cmd_e'(cmd_r))
          bte_pkg::CMD_SET: begin
            if (!set_ph_r) begin
              if (head_match) dup_nxt = 1'b1;
              if (!head.active && !have_r) begin
                have_nxt = 1'b1;
                free_nxt = k_r;
              end
            end else if (k_r == tgt_r) begin
              // restore a replaced breakpoint, then install the new one
              want_emit = head.active;
              tail      = '{addr: addr_r, saved: dinst_r, active: 1'b1};
            end
          end
          bte_pkg::CMD_REMOVE: begin
            if (k_r == bte_pkg::idx_t'(slot_r) && !slot_oob && head.active) begin
              want_emit   = 1'b1;
              tail.active = 1'b0;
            end
          end
          bte_pkg::CMD_REMOVE_ALL, bte_pkg::CMD_MASK, bte_pkg::CMD_UNMASK: begin
            if (head.active && cnt_r < bte_pkg::cnt_t'(bte_pkg::MAX_RESULTS)) begin
              want_emit = 1'b1;
              if (bte_pkg::cmd_e'(cmd_r) == bte_pkg::CMD_UNMASK) begin
                emit_item.write_data = bpt_inst;
              end
              if (bte_pkg::cmd_e'(cmd_r) == bte_pkg::CMD_REMOVE_ALL) begin
                tail.active = 1'b0;
              end
              if (emit_ok) cnt_nxt = cnt_r + 1'b1;
            end
          end
          bte_pkg::CMD_RANGE: begin
            if (range_hit) hit_nxt = 1'b1;
          end
          bte_pkg::CMD_FIND: begin
            if (head_match && !found_r) begin
              found_nxt = 1'b1;
              fidx_nxt  = k_r;
            end
          end
          default: ;
        endcase

        adv = !want_emit || emit_ok;
        if (adv) begin
          if (k_r == bte_pkg::idx_t'(bte_pkg::NUM_ENTRIES - 1)) begin
            k_nxt = '0;
            if (bte_pkg::cmd_e'(cmd_r) == bte_pkg::CMD_SET && !set_ph_r) begin
              set_err = dup_nxt || (any_r && !have_nxt) || (!any_r && slot_oob);
              if (set_err) begin
                state_nxt = bte_pkg::ST_FLUSH;
              end else begin
                tgt_nxt    = any_r ? free_nxt : bte_pkg::idx_t'(slot_r);
                set_ph_nxt = 1'b1;
              end
            end else if (bte_pkg::cmd_e'(cmd_r) == bte_pkg::CMD_SET) begin
              state_nxt = bte_pkg::ST_SET_WR;
            end else begin
              state_nxt = bte_pkg::ST_FLUSH;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end

      bte_pkg::ST_SET_WR: begin
        want_emit             = 1'b1;
        emit_item.result_slot = bte_pkg::slot_t'(tgt_r);
        emit_item.mem_write   = 1'b1;
        emit_item.write_addr  = addr_r;
        emit_item.write_data  = bpt_inst;
        if (emit_ok) state_nxt = bte_pkg::ST_FLUSH;
      end

      bte_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_nxt        = pend_valid_r ? pend_r : dflt_item;
          pend_valid_nxt = 1'b0;
          state_nxt      = bte_pkg::ST_IDLE;
        end
      end

      default: state_nxt = bte_pkg::ST_IDLE;
    endcase

    // a new result pushes the previous pending one out, which is then not the last
    if (want_emit && emit_ok) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = emit_item;
    end
  end

  assign chain_ctl.shift = adv && (state_r == bte_pkg::ST_PASS);
  assign chain_ctl.tail  = tail;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.found       = out_r.found;
  assign out_ch.result_slot = out_r.result_slot;
  assign out_ch.mem_write   = out_r.mem_write;
  assign out_ch.write_addr  = out_r.write_addr;
  assign out_ch.write_data  = out_r.write_data;
  assign out_ch.last        = out_last_r;

`ifndef SYNTHESIS
  // ring must be realigned whenever no pass is running
  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bte_pkg::ST_IDLE |-> k_r == '0)
    else $error("ring not aligned at idle");

  a_shift_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    chain_ctl.shift |-> state_r == bte_pkg::ST_PASS)
    else $error("chain shifted outside a pass");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bte_pkg::cnt_t'(bte_pkg::MAX_RESULTS))
    else $error("walk emitted too many results");

  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !pend_valid_r)
    else $error("command accepted with a result still pending");

  a_set_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bte_pkg::ST_SET_WR |-> set_ph_r && $past(state_r) == bte_pkg::ST_PASS ||
                                      $past(state_r) == bte_pkg::ST_SET_WR)
    else $error("breakpoint write issued without install pass");
`endif

endmodule

>>> hw/rtl/breakpoint_table_engine_unit.sv
// Breakpoint table engine: eight entries (address, saved instruction word,
// active flag) kept in a ring of cells that rotates one place per cycle.
// in_ch takes one command transaction (set, remove, remove all, mask,
// unmask, range check, find). out_ch returns one or more result
// transactions for it, the final one flagged with last; results that
// request memory writes carry write_addr and write_data.
// Each command but an unused code rotates the ring once, one entry per
// cycle unless stalled; its final result is then registered on out_ch from the
// flush state, and only then can the next command be taken, so commands do not
// overlap. Set scans the ring, then rotates it again to install and writes the
// trap word from its write state; a refused set ends after the scan.
// An unused command code skips the ring and returns an error result.
// in_ch.ready is high only between commands; the next command is taken
// while the final result of the previous one still waits in out_ch.
// A stalled out_ch holds its result; the ring stops rotating when a new
// result finds both the output register and the pending register full.
// The cfg port (APB write, setup and access cycle) sets bpt_instruction at
// byte address 0; write it only while no command is in progress.
// Synchronous reset clears all active flags, bpt_instruction and the valid
// flags of both result registers; addresses and saved words are left unset.
module breakpoint_table_engine_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  bte_in_if.sink                       in_ch,
  bte_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bte_pkg::CFG_AW-1:0]   cfg_paddr,
  input  bte_pkg::cfg_data_t           cfg_pwdata,
  output bte_pkg::cfg_data_t           cfg_prdata,
  output logic                         cfg_pready
);

  bte_pkg::inst_t      bpt_r;
  bte_pkg::chain_ctl_t chain_ctl;
  bte_pkg::entry_t     cell_q [bte_pkg::NUM_ENTRIES];

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpt_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == bte_pkg::REG_BPT_INST) begin
      bpt_r <= bte_pkg::inst_t'(cfg_pwdata);
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == bte_pkg::REG_BPT_INST) ?
                      bte_pkg::cfg_data_t'(bpt_r) : '0;

  // cell 0 is the head seen by the controller; the tail cell takes the
  // possibly updated head entry
  for (genvar j = 0; j < bte_pkg::NUM_ENTRIES; j++) begin : g_cell
    if (j == bte_pkg::NUM_ENTRIES - 1) begin : g_tail
      bte_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (chain_ctl.shift),
        .d     (chain_ctl.tail),
        .q     (cell_q[j])
      );
    end else begin : g_mid
      bte_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (chain_ctl.shift),
        .d     (cell_q[j+1]),
        .q     (cell_q[j])
      );
    end
  end

  bte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .bpt_inst  (bpt_r),
    .head      (cell_q[0]),
    .chain_ctl (chain_ctl)
  );

endmodule

>>> verif/bte_table_checker.sv
`timescale 1ns / 1ps

module bte_table_checker
  import bte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bte_in_if                 cmd_ch,
  bte_out_if                res_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  cfg_data_t         cfg_pwdata,
  input  logic              cfg_pready,
  output int                mismatches,
  output int                replies_due
);

  typedef struct packed {
    logic  status;
    logic  found;
    slot_t slot;
    logic  mem_write;
    addr_t waddr;
    inst_t wdata;
    logic  last;
  } reply_t;

  addr_t  bp_addr   [NUM_ENTRIES];
  inst_t  bp_saved  [NUM_ENTRIES];
  logic   bp_active [NUM_ENTRIES];
  inst_t  trap_word;
  reply_t table_replies [$];
  int     bad_count = 0;

  function automatic reply_t reply(input logic st, input logic fnd, input int sl,
                                   input logic wr, input addr_t wa, input inst_t wd);
    reply_t r;
    r.status    = st;
    r.found     = fnd;
    r.slot      = slot_t'(sl);
    r.mem_write = wr;
    r.waddr     = wr ? wa : '0;
    r.wdata     = wr ? wd : '0;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic string show(input reply_t r);
    return $sformatf("status=%0d found=%0d slot=%0d wr=%0d addr=%h data=%h last=%0d",
                     r.status, r.found, r.slot, r.mem_write, r.waddr, r.wdata, r.last);
  endfunction

  task automatic run_table_command(input cmd_t cmd, input slot_t slot, input logic any_slot,
                                   input addr_t addr, input len_t length, input inst_t dinst);
    reply_t batch [MAX_RESULTS];
    int     n;
    int     tgt;
    logic   have;
    logic   refused;
    logic   hit;
    n = 0;
    tgt = 0;
    have = 1'b0;
    refused = 1'b0;
    hit = 1'b0;
    case (cmd)
      CMD_SET: begin
        // a duplicate address is refused even when it sits in the target slot
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (!bp_active[i]) begin
            if (!have) begin
              have = 1'b1;
              tgt = i;
            end
          end else if (bp_addr[i] == addr) begin
            refused = 1'b1;
          end
        end
        if (!any_slot) begin
          tgt = int'(slot);
        end else if (!have) begin
          refused = 1'b1;
        end
        if (tgt >= NUM_ENTRIES) refused = 1'b1;
        if (!refused) begin
          if (bp_active[tgt]) begin
            batch[n] = reply(1'b0, 1'b0, tgt, 1'b1, bp_addr[tgt], bp_saved[tgt]);
            n++;
          end
          bp_addr[tgt] = addr;
          bp_saved[tgt] = dinst;
          bp_active[tgt] = 1'b1;
          batch[n] = reply(1'b0, 1'b0, tgt, 1'b1, addr, trap_word);
          n++;
        end
      end
      CMD_REMOVE: begin
        if (int'(slot) >= NUM_ENTRIES || !bp_active[slot]) begin
          refused = 1'b1;
        end else begin
          batch[0] = reply(1'b0, 1'b0, slot, 1'b1, bp_addr[slot], bp_saved[slot]);
          n = 1;
          bp_active[slot] = 1'b0;
        end
      end
      CMD_REMOVE_ALL, CMD_MASK, CMD_UNMASK: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (bp_active[i] && n < MAX_RESULTS) begin
            batch[n] = reply(1'b0, 1'b0, i, 1'b1, bp_addr[i],
                             (cmd == CMD_UNMASK) ? trap_word : bp_saved[i]);
            n++;
            if (cmd == CMD_REMOVE_ALL) bp_active[i] = 1'b0;
          end
        end
        if (n == 0) begin
          batch[0] = reply(1'b0, 1'b0, 0, 1'b0, '0, '0);
          n = 1;
        end
      end
      CMD_RANGE: begin
        // no wrap: start inside a breakpoint, or breakpoint inside the access
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (bp_active[i]) begin
            if (addr >= bp_addr[i]) begin
              if (addr_t'(addr - bp_addr[i]) < INST_BYTES) hit = 1'b1;
            end else if (addr_t'(bp_addr[i] - addr) < addr_t'(length)) begin
              hit = 1'b1;
            end
          end
        end
        batch[0] = reply(hit, 1'b0, 0, 1'b0, '0, '0);
        n = 1;
      end
      CMD_FIND: begin
        batch[0] = reply(1'b0, 1'b0, 0, 1'b0, '0, '0);
        // walk downward so the lowest matching slot is kept
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
          if (bp_active[i] && bp_addr[i] == addr) batch[0] = reply(1'b0, 1'b1, i, 1'b0, '0, '0);
        end
        n = 1;
      end
      default: begin
        refused = 1'b1;
      end
    endcase
    if (refused) begin
      batch[0] = reply(1'b1, 1'b0, 0, 1'b0, '0, '0);
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) batch[k].last = 1'b1;
      table_replies.push_back(batch[k]);
    end
  endtask

  task automatic check_reply();
    reply_t got;
    reply_t want;
    got.status    = res_ch.status;
    got.found     = res_ch.found;
    got.slot      = res_ch.result_slot;
    got.mem_write = res_ch.mem_write;
    got.waddr     = res_ch.write_addr;
    got.wdata     = res_ch.write_data;
    got.last      = res_ch.last;
    if (table_replies.size() == 0) begin
      bad_count++;
      if (bad_count <= 10) $display("result transaction with none expected: %s", show(got));
    end else begin
      want = table_replies.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.slot !== want.slot || got.mem_write !== want.mem_write ||
          got.waddr !== want.waddr || got.wdata !== want.wdata || got.last !== want.last) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("result mismatch: expected %s", show(want));
          $display("                 actual   %s", show(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        bp_active[i] = 1'b0;
        bp_addr[i] = '0;
        bp_saved[i] = '0;
      end
      trap_word = '0;
      table_replies.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_BPT_INST) begin
        trap_word = cfg_pwdata[INST_W-1:0];
      end
      if (res_ch.valid && res_ch.ready) check_reply();
      if (cmd_ch.valid && cmd_ch.ready) begin
        run_table_command(cmd_ch.cmd, cmd_ch.slot, cmd_ch.any_slot, cmd_ch.addr,
                          cmd_ch.length, cmd_ch.displaced_inst);
      end
    end
    replies_due <= table_replies.size();
    mismatches <= bad_count;
  end

endmodule

>>> verif/tb_breakpoint_table_engine_unit.sv
`timescale 1ns / 1ps

module tb_breakpoint_table_engine_unit;
  import bte_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 2 * NUM_ENTRIES + 8;
  localparam int POOL_SIZE   = 12;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 33;
  localparam cmd_t CMD_UNUSED = 3'd7;
  localparam logic [CFG_AW-1:0] BPT_INST_ADDR = {REG_BPT_INST, 2'b00};

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  cfg_data_t         cfg_pwdata;
  cfg_data_t         cfg_prdata;
  logic              cfg_pready;

  int    mismatches;
  int    replies_due;
  int    cycles = 0;
  int    in_calm = 0;
  int    out_calm = 0;
  addr_t addr_pool [POOL_SIZE];

  bte_in_if  in_ch ();
  bte_out_if out_ch ();

  breakpoint_table_engine_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bte_table_checker table_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_ch      (in_ch),
    .res_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_breakpoint_table_engine_unit failed");
      $finish;
    end
  end

  // random gap per transaction, with occasional back-to-back stretches
  function automatic int draw_gap(inout int calm);
    if (calm == 0 && $urandom_range(0, 19) == 0) calm = $urandom_range(4, 24);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic issue(input cmd_t cmd, input slot_t slot, input logic any_slot,
                       input addr_t addr, input len_t length, input inst_t inst);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= cmd;
    in_ch.slot           <= slot;
    in_ch.any_slot       <= any_slot;
    in_ch.addr           <= addr;
    in_ch.length         <= length;
    in_ch.displaced_inst <= inst;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic cfg_write(input inst_t word);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= BPT_INST_ADDR;
    cfg_pwdata  <= {16'($urandom), word};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (replies_due == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // addresses reused so that duplicates, finds and overlaps actually happen
  task automatic refill_pool();
    for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = addr_t'($urandom);
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = addr_pool[3] + 1;
    addr_pool[4] = addr_pool[5] + 2;
  endtask

  task automatic random_command();
    cmd_t  cmd;
    addr_t addr;
    len_t  length;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 34)      cmd = CMD_SET;
    else if (r < 48) cmd = CMD_REMOVE;
    else if (r < 62) cmd = CMD_FIND;
    else if (r < 78) cmd = CMD_RANGE;
    else if (r < 84) cmd = CMD_REMOVE_ALL;
    else if (r < 90) cmd = CMD_MASK;
    else if (r < 96) cmd = CMD_UNMASK;
    else             cmd = CMD_UNUSED;
    addr = ($urandom_range(0, 4) == 0) ? addr_t'($urandom)
                                        : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    length = ($urandom_range(0, 3) == 0) ? len_t'($urandom) : len_t'($urandom_range(0, 6));
    if (cmd == CMD_RANGE) addr = addr_t'(addr - 3 + $urandom_range(0, 4));
    issue(cmd, slot_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), addr, length,
          inst_t'($urandom));
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      int gap;
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    inst_t phase_word;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= CMD_SET;
    in_ch.slot           <= '0;
    in_ch.any_slot       <= 1'b0;
    in_ch.addr           <= '0;
    in_ch.length         <= '0;
    in_ch.displaced_inst <= '0;
    cfg_psel             <= 1'b0;
    cfg_penable          <= 1'b0;
    cfg_pwrite           <= 1'b0;
    cfg_paddr            <= '0;
    cfg_pwdata           <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(16'hA5C3);

    // empty table corners
    issue(CMD_MASK, '0, 1'b0, '0, '0, '0);
    issue(CMD_REMOVE_ALL, '0, 1'b0, '0, '0, '0);
    issue(CMD_UNMASK, '0, 1'b0, '0, '0, '0);
    issue(CMD_REMOVE, 3'd3, 1'b0, '0, '0, '0);
    issue(CMD_FIND, '0, 1'b0, '0, '0, '0);
    issue(CMD_RANGE, '0, 1'b0, '0, '0, '0);
    issue(CMD_UNUSED, 3'd7, 1'b1, '1, '1, '1);
    // sets at the address extremes, first free slot, duplicates and replacement
    issue(CMD_SET, 3'd0, 1'b0, 32'h0000_0000, 8'd0, 16'h0000);
    issue(CMD_SET, 3'd7, 1'b0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    issue(CMD_SET, 3'd7, 1'b1, 32'h0000_1000, 8'd0, 16'h1234);
    issue(CMD_SET, 3'd5, 1'b0, 32'h0000_1000, 8'd0, 16'h4321);
    issue(CMD_SET, 3'd1, 1'b0, 32'h0000_1000, 8'd0, 16'h4321);
    issue(CMD_SET, 3'd1, 1'b0, 32'h0000_2000, 8'd0, 16'h5A5A);
    issue(CMD_FIND, '0, 1'b0, 32'h0000_2000, '0, '0);
    issue(CMD_FIND, '0, 1'b0, 32'hFFFF_FFFF, '0, '0);
    // access ending just short of a breakpoint, spanning one, zero length inside one
    issue(CMD_RANGE, '0, 1'b0, 32'h0000_1FFF, 8'd1, '0);
    issue(CMD_RANGE, '0, 1'b0, 32'h0000_1FFF, 8'd2, '0);
    issue(CMD_RANGE, '0, 1'b0, 32'h0000_2001, 8'd0, '0);
    issue(CMD_MASK, '0, 1'b0, '0, '0, '0);
    issue(CMD_UNMASK, '0, 1'b0, '0, '0, '0);
    issue(CMD_REMOVE, 3'd0, 1'b0, '0, '0, '0);
    for (int k = 0; k < 6; k++) begin
      issue(CMD_SET, '0, 1'b1, addr_t'(32'h3000 + 2 * k), '0, inst_t'($urandom));
    end
    // table full now
    issue(CMD_SET, '0, 1'b1, 32'h0000_4000, '0, 16'h7777);
    issue(CMD_REMOVE_ALL, '0, 1'b0, '0, '0, '0);
    issue(CMD_REMOVE, 3'd7, 1'b0, '0, '0, '0);
    quiesce();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_word = 16'h0000;
        1:       phase_word = 16'hFFFF;
        default: phase_word = inst_t'($urandom);
      endcase
      cfg_write(phase_word);
      refill_pool();
      repeat (PHASE_ITEMS) random_command();
      quiesce();
    end

    if (mismatches == 0) begin
      $display("tb_breakpoint_table_engine_unit passed");
    end else begin
      $display("tb_breakpoint_table_engine_unit failed");
    end
    $finish;
  end

endmodule
